/* design/sallen_key_trapezoidal_filter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Sallen-Key trapezoidal filter
// Expect clk and rst_n in the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SALLEN_KEY_TRAPEZOIDAL_FILTER_MACROS_SVH
`define SALLEN_KEY_TRAPEZOIDAL_FILTER_MACROS_SVH

// same-cycle implication
`define SKT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, constants and the microcode program of the filter.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_STATE_WIDTH  = 32;

    localparam int COEF_W        = 30;
    localparam int COEF_NARROW_W = 29;
    localparam int COEF_FRAC     = 28;
    localparam int LO_BITS       = 14;
    localparam int HI_BITS       = COEF_W - LO_BITS;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = COEF_W;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_WAIT     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST_OP = 5'd1;
    localparam logic [STEP_W-1:0] STEP_LAST     = 5'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE    = 3'd0,
        REG_FB_GAIN = 3'd1,
        REG_A1      = 3'd2,
        REG_A2      = 3'd3,
        REG_A3      = 3'd4,
        REG_A4      = 3'd5,
        REG_A5      = 3'd6
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LP = 2'd0,
        MODE_BP = 2'd1,
        MODE_HP = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        SRC_C2,
        SRC_C1,
        SRC_X,
        SRC_V1,
        SRC_V2
    } src_t;

    typedef enum logic [2:0] {
        CF_A1,
        CF_A2,
        CF_A3,
        CF_A4,
        CF_A5,
        CF_K
    } coef_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        src_t              mul_src;
        coef_t             coef;
        logic              hi;
        logic              lo_cap;
        logic              term;
        acc_op_t           acc_op;
        logic              wr_v1;
        logic              wr_v2;
        logic              wr_c1;
        logic              wr_c2;
        logic              wr_y;
        cond_t             cond;
        logic              jump;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        ucode_t cw;
        logic   take_item;
        logic   emit_result;
    } ctl_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [COEF_W-1:0]        k;
        logic [COEF_W-1:0]        a1;
        logic [COEF_W-1:0]        a2;
        logic [COEF_W-1:0]        a3;
        logic [COEF_NARROW_W-1:0] a4;
        logic [COEF_NARROW_W-1:0] a5;
    } cfg_t;

    localparam ucode_t UCODE_NOP = '{
        mul_src: SRC_C2,
        coef:    CF_A1,
        hi:      1'b0,
        lo_cap:  1'b0,
        term:    1'b0,
        acc_op:  ACC_NONE,
        wr_v1:   1'b0,
        wr_v2:   1'b0,
        wr_c1:   1'b0,
        wr_c2:   1'b0,
        wr_y:    1'b0,
        cond:    COND_NEXT,
        jump:    1'b0,
        target:  STEP_WAIT
    };

    // Each coefficient product takes a lo and a hi multiply, then a term
    // step that joins them, then an accumulate; the products of a1 to a5 overlap.
    function automatic ucode_t skt_ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = UCODE_NOP;
        case (step)
            5'd0:
            begin
                w.cond = COND_WAIT_IN;
            end
            5'd1:
            begin
                w.mul_src = SRC_C2; w.coef = CF_A1;
            end
            5'd2:
            begin
                w.mul_src = SRC_C2; w.coef = CF_A1; w.hi = 1'b1; w.lo_cap = 1'b1;
            end
            5'd3:
            begin
                w.mul_src = SRC_C1; w.coef = CF_A2; w.term = 1'b1;
            end
            5'd4:
            begin
                w.mul_src = SRC_C1; w.coef = CF_A2; w.hi = 1'b1; w.lo_cap = 1'b1;
                w.acc_op  = ACC_LOAD;
            end
            5'd5:
            begin
                w.mul_src = SRC_X; w.coef = CF_A3; w.term = 1'b1;
            end
            5'd6:
            begin
                w.mul_src = SRC_X; w.coef = CF_A3; w.hi = 1'b1; w.lo_cap = 1'b1;
                w.acc_op  = ACC_ADD;
            end
            5'd7:
            begin
                w.mul_src = SRC_C2; w.coef = CF_A4; w.term = 1'b1;
            end
            5'd8:
            begin
                w.mul_src = SRC_C2; w.coef = CF_A4; w.hi = 1'b1; w.lo_cap = 1'b1;
                w.acc_op  = ACC_ADD;
            end
            5'd9:
            begin
                w.term = 1'b1; w.wr_v1 = 1'b1;
            end
            5'd10:
            begin
                w.mul_src = SRC_V1; w.coef = CF_A5; w.acc_op = ACC_LOAD;
            end
            5'd11:
            begin
                w.mul_src = SRC_V1; w.coef = CF_A5; w.hi = 1'b1; w.lo_cap = 1'b1;
            end
            5'd12:
            begin
                w.term = 1'b1;
            end
            5'd13:
            begin
                w.acc_op = ACC_ADD;
            end
            5'd14:
            begin
                w.wr_v2 = 1'b1;
            end
            5'd15:
            begin
                w.mul_src = SRC_V2; w.coef = CF_K; w.wr_c2 = 1'b1; w.wr_y = 1'b1;
            end
            5'd16:
            begin
                w.mul_src = SRC_V2; w.coef = CF_K; w.hi = 1'b1; w.lo_cap = 1'b1;
            end
            5'd17:
            begin
                w.term = 1'b1;
            end
            5'd18:
            begin
                w.acc_op = ACC_LOAD;
            end
            5'd19:
            begin
                w.wr_c1 = 1'b1;
            end
            5'd20:
            begin
                w.cond = COND_WAIT_OUT; w.jump = 1'b1; w.target = STEP_WAIT;
            end
            default:
            begin
                w.jump = 1'b1; w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/sallen_key_trapezoidal_filter.sv */
// ----------------------------------------------------------------------------
// sallen_key_trapezoidal_filter
// A new item is taken only after the microcode program has finished the
// previous one; the program runs six coefficient products, each as two
// passes through one shared multiplier.
// Reset clears the filter state, the coefficient registers and the handshake.
// ----------------------------------------------------------------------------
module sallen_key_trapezoidal_filter
    import skt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int STATE_WIDTH  = DEF_STATE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           clipped,
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata
);

    cfg_t cfg_reg;
    ctl_t ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:    cfg_reg.mode <= cfg_wdata[MODE_W-1:0];
                REG_FB_GAIN: cfg_reg.k    <= cfg_wdata[COEF_W-1:0];
                REG_A1:      cfg_reg.a1   <= cfg_wdata[COEF_W-1:0];
                REG_A2:      cfg_reg.a2   <= cfg_wdata[COEF_W-1:0];
                REG_A3:      cfg_reg.a3   <= cfg_wdata[COEF_W-1:0];
                REG_A4:      cfg_reg.a4   <= cfg_wdata[COEF_NARROW_W-1:0];
                REG_A5:      cfg_reg.a5   <= cfg_wdata[COEF_NARROW_W-1:0];
                default:     cfg_reg      <= cfg_reg;
            endcase
        end
    end

    skt_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctl          (ctl)
    );

    skt_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cfg        (cfg_reg),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

endmodule

/* design/skt_sequencer.sv */
// ----------------------------------------------------------------------------
// skt_sequencer
// Step counter over the microcode table, wait conditions and handshakes.
// ----------------------------------------------------------------------------
`include "sallen_key_trapezoidal_filter_macros.svh"

module skt_sequencer
    import skt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    output logic result_valid,
    input  logic result_stall,
    output ctl_t ctl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    ucode_t            cw;
    logic              take;
    logic              out_busy;
    logic              emit;
    logic              hold;

    assign cw         = skt_ucode(step_reg);
    assign item_stall = (cw.cond != COND_WAIT_IN);
    assign take       = item_valid && !item_stall;
    assign out_busy   = out_valid_reg && result_stall;
    assign emit       = (cw.cond == COND_WAIT_OUT) && !out_busy;
    assign hold       = ((cw.cond == COND_WAIT_IN) && !item_valid)
                     || ((cw.cond == COND_WAIT_OUT) && out_busy);

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (cw.jump)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid    = out_valid_reg;
    assign ctl.cw          = cw;
    assign ctl.take_item   = take;
    assign ctl.emit_result = emit;

    `SKT_ASSERT_IMP(a_step_range, 1'b1, step_reg <= STEP_LAST, "step counter left the program")
    `SKT_ASSERT_NXT(a_take_starts, take, step_reg == STEP_FIRST_OP, "item did not start program")
    `SKT_ASSERT_IMP(a_valid_from_last, $rose(out_valid_reg), $past(step_reg) == STEP_LAST, "result without last step")
    `SKT_ASSERT_NXT(a_step_advance, (step_reg != STEP_WAIT) && (step_reg != STEP_LAST), step_reg == $past(step_reg) + STEP_W'(1), "program step skipped")

endmodule

/* design/skt_datapath.sv */
// ----------------------------------------------------------------------------
// skt_datapath
// Shared coefficient multiplier, term and accumulator registers, filter state.
// ----------------------------------------------------------------------------
module skt_datapath
    import skt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int STATE_WIDTH  = DEF_STATE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctl_t                           ctl,
    input  cfg_t                           cfg,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           clipped
);

    localparam int SW   = STATE_WIDTH;
    localparam int XW   = SAMPLE_WIDTH;
    localparam int PW   = SW + HI_BITS + 1;
    localparam int TW   = SW + COEF_W + 1;
    localparam int FW   = TW - COEF_FRAC;
    localparam int AW   = SW + 4;
    localparam int EW   = SW + 5;
    localparam int MW   = SW + XW + 2;
    localparam int FS   = SW - 8 - (XW - 1);
    localparam int FS_L = (FS >= 0) ? FS : 0;
    localparam int FS_R = (FS < 0) ? -FS : 0;

    localparam logic signed [EW-1:0] ST_MAX  = (EW'(1) <<< (SW - 1)) - EW'(1);
    localparam logic signed [EW-1:0] ST_MIN  = -ST_MAX - EW'(1);
    localparam logic signed [MW-1:0] SMP_MAX = (MW'(1) <<< (XW - 1)) - MW'(1);
    localparam logic signed [MW-1:0] SMP_MIN = -SMP_MAX - MW'(1);

    function automatic logic st_ovf(input logic signed [EW-1:0] v);
        return (v > ST_MAX) || (v < ST_MIN);
    endfunction

    function automatic logic signed [SW-1:0] st_sat(input logic signed [EW-1:0] v);
        if (v > ST_MAX)
            return SW'(ST_MAX);
        if (v < ST_MIN)
            return SW'(ST_MIN);
        return SW'(v);
    endfunction

    logic signed [SW-1:0]   v1_reg, v2_reg, c1_reg, c2_reg, x_reg;
    logic signed [PW-1:0]   prod_reg, lo_reg;
    logic signed [TW-1:0]   term_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [XW-1:0]   y_reg;
    logic                   clip_reg;
    logic signed [XW-1:0]   sample_out_reg;
    logic                   clipped_reg;

    logic signed [SW-1:0]   mul_a;
    logic [COEF_W-1:0]      coef_full;
    logic [HI_BITS-1:0]     half;
    logic signed [HI_BITS:0] mul_b;
    logic signed [PW-1:0]   mul_prod;
    logic signed [TW-1:0]   term_sum;
    logic signed [FW-1:0]   term_fl;
    logic signed [AW-1:0]   acc_sum;
    logic signed [EW-1:0]   acc_ext;
    logic signed [EW-1:0]   c1_new;
    logic signed [EW-1:0]   c2_new;
    logic signed [MW-1:0]   xs_ext;
    logic signed [MW-1:0]   x_full;
    logic signed [MW-1:0]   diff;
    logic signed [MW-1:0]   diff_sh;
    logic                   y_ovf;
    logic signed [XW-1:0]   y_sat;
    logic                   flags;

    always_comb
    begin
        case (ctl.cw.mul_src)
            SRC_C2:  mul_a = c2_reg;
            SRC_C1:  mul_a = c1_reg;
            SRC_X:   mul_a = x_reg;
            SRC_V1:  mul_a = v1_reg;
            SRC_V2:  mul_a = v2_reg;
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.cw.coef)
            CF_A1:   coef_full = cfg.a1;
            CF_A2:   coef_full = cfg.a2;
            CF_A3:   coef_full = cfg.a3;
            CF_A4:   coef_full = {1'b0, cfg.a4};
            CF_A5:   coef_full = {1'b0, cfg.a5};
            CF_K:    coef_full = cfg.k;
            default: coef_full = '0;
        endcase
    end

    assign half     = ctl.cw.hi ? coef_full[COEF_W-1:LO_BITS]
                                : {{(HI_BITS - LO_BITS){1'b0}}, coef_full[LO_BITS-1:0]};
    assign mul_b    = $signed({1'b0, half});
    assign mul_prod = PW'(mul_a) * PW'(mul_b);

    // hi partial product carries weight 2^14 over the lo one
    assign term_sum = (TW'(prod_reg) <<< LO_BITS) + TW'(lo_reg);
    assign term_fl  = $signed(term_reg[TW-1:COEF_FRAC]);
    assign acc_sum  = acc_reg + AW'(term_fl);
    assign acc_ext  = EW'(acc_reg);

    // at the c1 step the accumulator holds k*v2
    assign c1_new = ((EW'(v1_reg) - acc_ext) <<< 1) - EW'(c1_reg);
    assign c2_new = (EW'(v2_reg) <<< 1) - EW'(c2_reg);

    assign xs_ext = MW'(sample_in);
    assign x_full = (xs_ext <<< FS_L) >>> FS_R;

    always_comb
    begin
        case (cfg.mode)
            MODE_LP: diff = MW'(v2_reg);
            MODE_BP: diff = MW'(v1_reg) - MW'(v2_reg);
            MODE_HP: diff = MW'(x_reg) - MW'(v2_reg);
            default: diff = '0;
        endcase
    end

    assign diff_sh = (diff >>> FS_L) <<< FS_R;
    assign y_ovf   = (diff_sh > SMP_MAX) || (diff_sh < SMP_MIN);

    always_comb
    begin
        if (diff_sh > SMP_MAX)
            y_sat = XW'(SMP_MAX);
        else if (diff_sh < SMP_MIN)
            y_sat = XW'(SMP_MIN);
        else
            y_sat = XW'(diff_sh);
    end

    assign flags = ((ctl.cw.wr_v1 || ctl.cw.wr_v2) && st_ovf(acc_ext))
                || (ctl.cw.wr_c1 && st_ovf(c1_new))
                || (ctl.cw.wr_c2 && st_ovf(c2_new))
                || (ctl.cw.wr_y && y_ovf);

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
        if (ctl.cw.lo_cap)
            lo_reg <= prod_reg;
        if (ctl.cw.term)
            term_reg <= term_sum;
        case (ctl.cw.acc_op)
            ACC_LOAD: acc_reg <= AW'(term_fl);
            ACC_ADD:  acc_reg <= acc_sum;
            default:  acc_reg <= acc_reg;
        endcase
        if (ctl.take_item)
            x_reg <= SW'(x_full);
        if (ctl.cw.wr_y)
            y_reg <= y_sat;
        if (ctl.emit_result)
        begin
            sample_out_reg <= y_reg;
            clipped_reg    <= clip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= '0;
            v2_reg   <= '0;
            c1_reg   <= '0;
            c2_reg   <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cw.wr_v1)
                v1_reg <= st_sat(acc_ext);
            if (ctl.cw.wr_v2)
                v2_reg <= st_sat(acc_ext);
            if (ctl.cw.wr_c1)
                c1_reg <= st_sat(c1_new);
            if (ctl.cw.wr_c2)
                c2_reg <= st_sat(c2_new);
            if (ctl.take_item)
                clip_reg <= 1'b0;
            else
                clip_reg <= clip_reg || flags;
        end
    end

    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule
